// File: rtl/lrcdf_pkg.sv
// Package for the LRC length-prefixed packet deframer.
// Result kind codes, size limits and field widths; no dependencies.
package lrcdf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned NSIZE_W  = 13;
  localparam int unsigned SIZE_W   = 9;   // holds MAX_PACKET
  localparam int unsigned LEN_W    = 17;  // 16-bit length plus the extra bytes

  localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(5);
  localparam logic [SIZE_W-1:0] MAX_PACKET = SIZE_W'(261);
  localparam logic [LEN_W-1:0]  LEN_EXTRA  = LEN_W'(3);

  // Header bytes are 0 and 1; the length field sits in bytes 2 and 3.
  localparam logic [SIZE_W-1:0] IDX_HDR_END = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] IDX_LEN_HI  = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] IDX_LEN_LO  = SIZE_W'(3);

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_DATA_OK  = 3'd1,
    KIND_LEN_OK   = 3'd2,
    KIND_LRC_DROP = 3'd3,
    KIND_BUS_DROP = 3'd4,
    KIND_BAD_LEN  = 3'd5
  } kind_t;

endpackage

// File: rtl/lrc_length_packet_deframer.sv
// Byte-serial deframer for an XOR-LRC protected, length-prefixed packet link.
// Single module; depends on lrcdf_pkg for kind codes, limits and widths.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   in      | input     | in_valid / in_stall   | in_rx_byte[7:0], in_bus_error
//   out     | output    | out_valid / out_stall | out_kind[2:0], out_payload[7:0],
//           |           |                       | out_next_size[12:0]
//
// Flow: one beat per clock while out_stall is low; a result passes from its input
//   beat through the input register, then the framing logic into the result register.
// Reset: rst_n low (synchronous) empties both registers, sets the expected
//   size to 5 and restarts the packet position and LRC.
// Stalls: out_stall holds the result register; the input register keeps moving
//   while the result register is empty or being drained, so in_stall only rises
//   when a held input beat has nowhere to go.
module lrc_length_packet_deframer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lrcdf_pkg::BYTE_W-1:0]       in_rx_byte,
  input  logic                               in_bus_error,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lrcdf_pkg::KIND_W-1:0]       out_kind,
  output logic [lrcdf_pkg::BYTE_W-1:0]       out_payload,
  output logic [lrcdf_pkg::NSIZE_W-1:0]      out_next_size
);
  import lrcdf_pkg::*;

  // ---------------- input register ----------------
  logic              s1_vld_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_err_r;
  logic              s1_go;     // result register can take the input register beat this cycle

  // ---------------- framing state ----------------
  logic [SIZE_W-1:0] exp_size_r, exp_size_nxt;
  logic [SIZE_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [BYTE_W-1:0] lrc_r,      lrc_nxt;
  logic              hdr_zero_r, hdr_zero_nxt;
  logic [BYTE_W-1:0] len_hi_r,   len_hi_nxt;
  logic [BYTE_W-1:0] len_lo_r,   len_lo_nxt;

  // ---------------- result register ----------------
  logic               out_vld_r, out_vld_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0]  out_pay_r,  out_pay_nxt;
  logic [SIZE_W-1:0]  out_size_r, out_size_nxt;

  logic               emit;
  logic [SIZE_W:0]    idx_inc;    // one bit wider: idx + 1 against the size
  logic [LEN_W-1:0]   len_size;
  logic               last_byte;

  // Result register is free when empty or when its beat leaves this cycle.
  assign s1_go    = ~out_vld_r | ~out_stall;
  assign in_stall = s1_vld_r & ~s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_rx_byte;
      s1_err_r  <= in_bus_error;
    end
  end

  // ---------------- framing logic ----------------
  always_comb begin
    exp_size_nxt = exp_size_r;
    byte_idx_nxt = byte_idx_r;
    lrc_nxt      = lrc_r;
    hdr_zero_nxt = hdr_zero_r;
    len_hi_nxt   = len_hi_r;
    len_lo_nxt   = len_lo_r;
    emit         = 1'b0;
    out_kind_nxt = KIND_PAYLOAD;
    out_pay_nxt  = '0;
    idx_inc      = {1'b0, byte_idx_r} + (SIZE_W+1)'(1);
    last_byte    = idx_inc >= {1'b0, exp_size_r};
    len_size     = {1'b0, len_hi_r, len_lo_r} + LEN_EXTRA;

    if (s1_err_r) begin
      // bus error: drop the packet in progress, keep the expected size
      byte_idx_nxt = '0;
      lrc_nxt      = '0;
      hdr_zero_nxt = 1'b1;
      len_hi_nxt   = '0;
      len_lo_nxt   = '0;
      emit         = 1'b1;
      out_kind_nxt = KIND_BUS_DROP;
    end else begin
      lrc_nxt = lrc_r ^ s1_byte_r;
      if (byte_idx_r < IDX_HDR_END && s1_byte_r != '0) begin
        hdr_zero_nxt = 1'b0;
      end
      if (byte_idx_r == IDX_LEN_HI) begin
        len_hi_nxt = s1_byte_r;
      end
      if (byte_idx_r == IDX_LEN_LO) begin
        len_lo_nxt = s1_byte_r;
      end
      len_size = {1'b0, len_hi_nxt, len_lo_nxt} + LEN_EXTRA;

      if (last_byte) begin
        emit = 1'b1;
        if (lrc_nxt != '0) begin
          exp_size_nxt = MIN_SIZE;
          out_kind_nxt = KIND_LRC_DROP;
        end else if (hdr_zero_nxt) begin
          if (len_size >= LEN_W'(MIN_SIZE) && len_size <= LEN_W'(MAX_PACKET)) begin
            exp_size_nxt = len_size[SIZE_W-1:0];
            out_kind_nxt = KIND_LEN_OK;
          end else begin
            exp_size_nxt = MIN_SIZE;
            out_kind_nxt = KIND_BAD_LEN;
          end
        end else begin
          exp_size_nxt = MIN_SIZE;
          out_kind_nxt = KIND_DATA_OK;
        end
        byte_idx_nxt = '0;
        lrc_nxt      = '0;
        hdr_zero_nxt = 1'b1;
        len_hi_nxt   = '0;
        len_lo_nxt   = '0;
      end else begin
        byte_idx_nxt = idx_inc[SIZE_W-1:0];
        if (byte_idx_r >= IDX_HDR_END && !hdr_zero_nxt) begin
          // data packet body (the LRC byte itself is never streamed)
          emit         = 1'b1;
          out_kind_nxt = KIND_PAYLOAD;
          out_pay_nxt  = s1_byte_r;
        end
      end
    end
    out_size_nxt = exp_size_nxt;
  end

  always_comb begin
    out_vld_nxt = out_vld_r & out_stall;
    if (s1_vld_r && s1_go) begin
      out_vld_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_size_r <= MIN_SIZE;
      byte_idx_r <= '0;
      lrc_r      <= '0;
      hdr_zero_r <= 1'b1;
      len_hi_r   <= '0;
      len_lo_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (s1_vld_r && s1_go) begin
        exp_size_r <= exp_size_nxt;
        byte_idx_r <= byte_idx_nxt;
        lrc_r      <= lrc_nxt;
        hdr_zero_r <= hdr_zero_nxt;
        len_hi_r   <= len_hi_nxt;
        len_lo_r   <= len_lo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_go && emit) begin
      out_kind_r <= out_kind_nxt;
      out_pay_r  <= out_pay_nxt;
      out_size_r <= out_size_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_kind      = out_kind_r;
  assign out_payload   = out_pay_r;
  assign out_next_size = NSIZE_W'(out_size_r);

  // ---------------- assertions ----------------
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    exp_size_r >= MIN_SIZE && exp_size_r <= MAX_PACKET)
    else $error("expected size out of range");

  a_idx_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r < exp_size_r)
    else $error("byte index past packet end");

  a_end_resyncs: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_kind_r == KIND_DATA_OK || out_kind_r == KIND_LRC_DROP ||
                  out_kind_r == KIND_BAD_LEN) |-> out_size_r == MIN_SIZE)
    else $error("packet end did not resync size");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_kind_r != KIND_PAYLOAD |-> out_pay_r == '0)
    else $error("payload not zero on status beat");

  a_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_vld_r && $stable(s1_byte_r) && $stable(byte_idx_r))
    else $error("held input beat lost or state moved");

endmodule

// File: tb/sv/lrc_length_packet_deframer_tb.sv
// Testbench for lrc_length_packet_deframer: directed and random packet traffic.
// Uses lrcdf_pkg for kind codes, limits and widths; checks against its own model.
module lrc_length_packet_deframer_tb;
  import lrcdf_pkg::*;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  // One result beat as the block should present it.
  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   payload;
    logic [NSIZE_W-1:0]  next_size;
  } frame_result_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 10;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                in_bus_error = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   out_kind;
  logic [BYTE_W-1:0]   out_payload;
  logic [NSIZE_W-1:0]  out_next_size;

  lrc_length_packet_deframer u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .in_bus_error  (in_bus_error),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_payload   (out_payload),
    .out_next_size (out_next_size)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Deframer model state, advanced once per accepted input beat.
  // ---------------------------------------------------------------------------
  int unsigned        cur_size = MIN_SIZE;  // expected byte count of this packet
  int unsigned        pos = 0;              // index of the next byte in the packet
  logic [BYTE_W-1:0]  lrc_sum = '0;         // running XOR of the packet so far
  bit                 hdr_clear = 1'b1;     // header bytes seen so far all zero
  logic [BYTE_W-1:0]  len_hi = '0;
  logic [BYTE_W-1:0]  len_lo = '0;

  frame_result_t      results_due[$];       // results still owed by the block

  int unsigned        mismatches = 0;
  int unsigned        beats_sent = 0;
  int unsigned        cycle_cnt = 0;

  // Idle controls: the source pauses before ~7% of beats and the sink stalls ~7% of cycles, each when its flag is set.
  bit                 src_gaps = 1'b1;
  bit                 sink_gaps = 1'b1;
  int unsigned        hold_req = 0;         // long receiver hold, in cycles
  int unsigned        hold_left = 0;

  function automatic void clear_packet();
    pos       = 0;
    lrc_sum   = '0;
    hdr_clear = 1'b1;
    len_hi    = '0;
    len_lo    = '0;
  endfunction

  // Advance the model by one beat and queue the result it causes, if any.
  function automatic void deframe_beat(logic [BYTE_W-1:0] b, logic err);
    frame_result_t r;
    int unsigned   idx;
    int unsigned   sz;
    bit            emits;
    emits     = 1'b0;
    r.kind    = KIND_PAYLOAD;
    r.payload = '0;
    if (err) begin
      // Bus error: drop the packet, keep the size, byte value is ignored.
      clear_packet();
      r.kind = KIND_BUS_DROP;
      emits  = 1'b1;
    end else begin
      idx     = pos;
      lrc_sum = lrc_sum ^ b;
      if (idx < IDX_HDR_END && b != '0) hdr_clear = 1'b0;
      if (idx == IDX_LEN_HI) len_hi = b;
      if (idx == IDX_LEN_LO) len_lo = b;
      if (idx + 1 >= cur_size) begin
        // Last byte of the packet carries the LRC.
        if (lrc_sum != '0) begin
          cur_size = MIN_SIZE;
          r.kind   = KIND_LRC_DROP;
        end else if (hdr_clear) begin
          sz = {len_hi, len_lo} + LEN_EXTRA;
          if (sz >= MIN_SIZE && sz <= MAX_PACKET) begin
            cur_size = sz;
            r.kind   = KIND_LEN_OK;
          end else begin
            cur_size = MIN_SIZE;
            r.kind   = KIND_BAD_LEN;
          end
        end else begin
          cur_size = MIN_SIZE;
          r.kind   = KIND_DATA_OK;
        end
        clear_packet();
        emits = 1'b1;
      end else begin
        pos = idx + 1;
        // Data packet body bytes stream straight out.
        if (idx >= IDX_HDR_END && !hdr_clear) begin
          r.kind    = KIND_PAYLOAD;
          r.payload = b;
          emits     = 1'b1;
        end
      end
    end
    if (emits) begin
      r.next_size = NSIZE_W'(cur_size);
      results_due.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side: drive at negedge, the beat counts when stall is low at posedge.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic err);
    @(negedge clk);
    if (src_gaps && $urandom_range(99) < 7) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_rx_byte   = b;
    in_bus_error = err;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_beat(b, err);
    beats_sent++;
  endtask

  // Sender goes quiet until every owed result has been taken.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Body then its LRC byte; a corrupted LRC is off by a nonzero mask.
  task automatic send_frame(input byte_q_t body, input bit corrupt);
    logic [BYTE_W-1:0] sum;
    sum = '0;
    foreach (body[i]) begin
      sum ^= body[i];
      send_beat(body[i], 1'b0);
    end
    if (corrupt) sum ^= BYTE_W'($urandom_range(1, 255));
    send_beat(sum, 1'b0);
  endtask

  // Mid-packet means our framing is off; a bus error restarts the position.
  task automatic align_packet();
    if (pos != 0) send_beat(BYTE_W'($urandom), 1'b1);
  endtask

  task automatic send_data_frame(input bit corrupt);
    byte_q_t body;
    align_packet();
    body.push_back(BYTE_W'($urandom));
    body.push_back(BYTE_W'($urandom));
    if (body[0] == '0 && body[1] == '0) body[1] = BYTE_W'($urandom_range(1, 255));
    while (body.size() < cur_size - 1) body.push_back(BYTE_W'($urandom));
    send_frame(body, corrupt);
  endtask

  task automatic send_length_frame(input logic [15:0] len, input bit corrupt);
    byte_q_t body;
    align_packet();
    body = '{8'h00, 8'h00, len[15:8], len[7:0]};
    while (body.size() < cur_size - 1) body.push_back(BYTE_W'($urandom));
    send_frame(body, corrupt);
  endtask

  // Mostly well-formed packets; sizes kept small, the largest now and then.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned r;
    logic [15:0] len;
    pick = $urandom_range(99);
    r    = $urandom_range(99);
    if (r < 3)       len = 16'(MAX_PACKET - LEN_EXTRA);
    else if (r < 88) len = 16'($urandom_range(2, 14));
    else             len = 16'($urandom_range(15, MAX_PACKET - LEN_EXTRA));
    if (pick < 40) begin
      send_data_frame(1'b0);
    end else if (pick < 68) begin
      send_length_frame(len, 1'b0);
    end else if (pick < 74) begin
      send_data_frame(1'b1);
    end else if (pick < 78) begin
      send_length_frame(len, 1'b1);
    end else if (pick < 86) begin
      // Length outside 5..MAX: too short, just past the top, or anywhere above.
      case ($urandom_range(3))
        0:       len = 16'($urandom_range(0, 1));
        1:       len = 16'(MAX_PACKET - LEN_EXTRA + 1);
        2:       len = 16'hFFFF;
        default: len = 16'($urandom_range(MAX_PACKET - LEN_EXTRA + 1, 16'hFFFF));
      endcase
      send_length_frame(len, 1'b0);
    end else if (pick < 93) begin
      // Packet cut short by a bus error.
      align_packet();
      repeat ($urandom_range(0, cur_size - 1)) send_beat(BYTE_W'($urandom), 1'b0);
      send_beat(BYTE_W'($urandom), 1'b1);
    end else begin
      // Raw noise, bus errors sprinkled in.
      repeat ($urandom_range(1, 8))
        send_beat(BYTE_W'($urandom), $urandom_range(9) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold on request.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
      out_stall = 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = sink_gaps && ($urandom_range(99) < 7);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted beat against the oldest owed result.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  frame_result_t head;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual kind %0d payload %0d size %0d",
                 $time, out_kind, out_payload, out_next_size);
      end else begin
        head = results_due.pop_front();
        check_field("kind", 16'(head.kind), 16'(out_kind));
        check_field("payload", 16'(head.payload), 16'(out_payload));
        check_field("next_size", 16'(head.next_size), 16'(out_next_size));
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bus drop while idle, minimum length packet, 00/FF payload, LRC drop,
  // oversize length, and a drop in the middle of a data packet.
  task automatic test_directed();
    byte_q_t body;
    send_beat(8'hA5, 1'b1);
    body = '{8'h00, 8'h00, 8'h00, 8'h02};
    send_frame(body, 1'b0);
    body = '{8'hFF, 8'h00, 8'hFF, 8'h00};
    send_frame(body, 1'b0);
    body = '{8'h12, 8'h34, 8'h56, 8'h78};
    send_frame(body, 1'b1);
    body = '{8'h00, 8'h00, 8'hFF, 8'hFF};
    send_frame(body, 1'b0);
    send_beat(8'h5A, 1'b0);
    send_beat(8'hC3, 1'b0);
    send_beat(8'h00, 1'b1);
  endtask

  // Largest packet, one past it, one under the minimum, back to the minimum.
  task automatic test_size_limits();
    send_length_frame(16'(MAX_PACKET - LEN_EXTRA), 1'b0);
    send_data_frame(1'b0);
    send_length_frame(16'(MAX_PACKET - LEN_EXTRA + 1), 1'b0);
    send_length_frame(16'd1, 1'b0);
    send_length_frame(16'd2, 1'b0);
  endtask

  // Receiver holds off while a 40-byte packet is offered back to back, so the
  // pipeline fills and the input stalls; then the sender waits out the drain.
  task automatic test_backpressure();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    send_length_frame(16'd37, 1'b0);
    wait_drained();
    hold_req = 80;
    send_data_frame(1'b0);
    wait_drained();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // Random traffic with no idling on either side.
  task automatic test_burst(input int unsigned n);
    int unsigned stop_at;
    stop_at   = beats_sent + n;
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    while (beats_sent < stop_at) send_random_frame();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned stop_at;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) send_random_frame();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_size_limits();
    test_backpressure();
    test_burst(250);
    test_random_traffic(700);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
